[sv/assert_macros.svh]
// Assertion macros used by the layout RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[sv/btww_pkg.sv]
// Types, constants and font tables for the word-wrap text layout block.
package btww_pkg;

  localparam int WORD_CAPACITY = 31;
  localparam int IDX_W         = 5;
  localparam int ROWS_W        = 49;
  localparam int DATA_W        = 80;

  localparam int SMALL_GLYPHS = 39;
  localparam int LARGE_GLYPHS = 33;

  localparam logic [5:0] NO_GLYPH  = 6'd63;
  localparam logic [5:0] IDX_DIGIT = 6'd26;
  localparam logic [5:0] IDX_COMMA = 6'd36;
  localparam logic [5:0] IDX_DOT   = 6'd37;
  localparam logic [5:0] IDX_SLASH = 6'd38;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_Z      = 8'h5A;

  localparam logic [2:0] PITCH_SMALL = 3'd5;
  localparam logic [2:0] PITCH_LARGE = 3'd6;
  localparam logic [2:0] GAP_WIDTH   = 3'd3;

  // Config register indexes
  localparam logic [1:0] REG_FONT   = 2'd0;
  localparam logic [1:0] REG_MAXLEN = 2'd1;
  localparam logic [1:0] REG_STARTX = 2'd2;
  localparam logic [1:0] REG_STARTY = 2'd3;

  typedef struct packed {
    logic              vis;
    logic [ROWS_W-1:0] rows;
  } glyph_t;

  // 4x4 font, row 0 in the top nibble
  localparam logic [15:0] SMALL_FONT [SMALL_GLYPHS] = '{
    16'hF9F9, 16'h8EAE, 16'hF88F, 16'hE99E, 16'hFE8F, 16'hFE88, 16'hF89F, 16'h88F9,
    16'h4444, 16'h444C, 16'hACA9, 16'h888F, 16'h9F99, 16'h9DB9, 16'hF99F, 16'hF9E8,
    16'hF9F1, 16'hE9CA, 16'hF81F, 16'hF444, 16'h999F, 16'h9531, 16'h9996, 16'h0A4A,
    16'h9622, 16'hF42F,
    16'h6AAC, 16'h2622, 16'h6246, 16'h6316, 16'h5711, 16'h6426, 16'h4653, 16'h7511,
    16'h7577, 16'h6531,
    16'h0048, 16'h0066, 16'h1248
  };

  // 7x7 font, row 0 in the top seven bits
  localparam logic [ROWS_W-1:0] LARGE_FONT [LARGE_GLYPHS] = '{
    {7'h00,7'h18,7'h24,7'h24,7'h3C,7'h24,7'h00},
    {7'h00,7'h3C,7'h20,7'h38,7'h24,7'h38,7'h00},
    {7'h00,7'h38,7'h24,7'h38,7'h24,7'h38,7'h00},
    {7'h00,7'h3C,7'h20,7'h20,7'h20,7'h20,7'h00},
    {7'h00,7'h0C,7'h14,7'h14,7'h3E,7'h22,7'h00},
    {7'h00,7'h3C,7'h20,7'h38,7'h20,7'h3C,7'h00},
    {7'h00,7'h2A,7'h2A,7'h1C,7'h2A,7'h2A,7'h00},
    {7'h00,7'h18,7'h04,7'h18,7'h04,7'h18,7'h00},
    {7'h00,7'h22,7'h26,7'h2A,7'h32,7'h22,7'h00},
    {7'h14,7'h08,7'h22,7'h26,7'h2A,7'h32,7'h00},
    {7'h00,7'h24,7'h28,7'h30,7'h28,7'h24,7'h00},
    {7'h00,7'h0C,7'h14,7'h14,7'h14,7'h24,7'h00},
    {7'h00,7'h22,7'h36,7'h2A,7'h22,7'h22,7'h00},
    {7'h00,7'h24,7'h24,7'h3C,7'h24,7'h24,7'h00},
    {7'h00,7'h18,7'h24,7'h24,7'h24,7'h18,7'h00},
    {7'h00,7'h3C,7'h24,7'h24,7'h24,7'h24,7'h00},
    {7'h00,7'h38,7'h24,7'h24,7'h38,7'h20,7'h00},
    {7'h00,7'h1C,7'h20,7'h20,7'h20,7'h1C,7'h00},
    {7'h00,7'h3E,7'h08,7'h08,7'h08,7'h08,7'h00},
    {7'h00,7'h24,7'h24,7'h1C,7'h04,7'h38,7'h00},
    {7'h00,7'h1C,7'h2A,7'h2A,7'h1C,7'h08,7'h00},
    {7'h00,7'h22,7'h14,7'h08,7'h14,7'h22,7'h00},
    {7'h00,7'h24,7'h24,7'h24,7'h24,7'h3E,7'h02},
    {7'h00,7'h24,7'h24,7'h1C,7'h04,7'h04,7'h00},
    {7'h00,7'h2A,7'h2A,7'h2A,7'h2A,7'h3E,7'h00},
    {7'h00,7'h2A,7'h2A,7'h2A,7'h2A,7'h3F,7'h01},
    {7'h00,7'h30,7'h10,7'h1C,7'h12,7'h1C,7'h00},
    {7'h00,7'h42,7'h42,7'h72,7'h4A,7'h72,7'h00},
    {7'h00,7'h20,7'h20,7'h38,7'h24,7'h38,7'h00},
    {7'h00,7'h38,7'h04,7'h1C,7'h04,7'h38,7'h00},
    {7'h00,7'h4C,7'h52,7'h72,7'h52,7'h4C,7'h00},
    {7'h00,7'h1C,7'h24,7'h1C,7'h24,7'h24,7'h00},
    {7'h14,7'h3C,7'h20,7'h38,7'h20,7'h3C,7'h00}
  };

  function automatic logic [5:0] glyph_index(input logic [7:0] c);
    logic [5:0] idx;
    if (c >= CH_A && c <= CH_Z)       idx = 6'(c - CH_A);
    else if (c >= CH_0 && c <= CH_9)  idx = 6'(c - CH_0) + IDX_DIGIT;
    else if (c == CH_COMMA)           idx = IDX_COMMA;
    else if (c == CH_PERIOD)          idx = IDX_DOT;
    else if (c == CH_SLASH)           idx = IDX_SLASH;
    else                              idx = NO_GLYPH;
    return idx;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [7:0] c, input logic font);
    logic [5:0]  idx;
    logic [15:0] s;
    glyph_t      g;
    idx    = glyph_index(c);
    g.vis  = 1'b0;
    g.rows = '0;
    if (!font) begin
      if (idx < 6'(SMALL_GLYPHS)) begin
        s      = SMALL_FONT[idx];
        g.vis  = 1'b1;
        // nibble sits in the top four bits of each 7-bit row
        g.rows = {s[15:12], 3'b000, s[11:8], 3'b000, s[7:4], 3'b000,
                  s[3:0], 3'b000, 21'd0};
      end
    end else begin
      if (idx < 6'(LARGE_GLYPHS)) begin
        g.vis  = 1'b1;
        g.rows = LARGE_FONT[idx];
      end
    end
    return g;
  endfunction

endpackage

[sv/bitmap_text_word_wrap_layout.sv]
// Greedy word-wrap text layout for a bitmap font, one shared adder under a sequencer.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: character
//  m_      | out | m_tvalid/m_tready  | m_tdata: pos_x, pos_y, glyph_rows; m_tuser: visible;
//          |     |                    | m_tlast: last
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
// Word bytes are stored while the sequencer idles. A flushing space or NUL steps through
// LIMIT, NEED, WRAP (on a wrap only), then READ, LOAD, SEND per character, then FIN; an
// empty space goes to FIN. The single 16-bit adder is used once per step, and the word
// store has a registered read. s_tready is low during a flush; a stall on m_tready holds
// the result register. Synchronous reset clears the cursor, word count and sequencer.
module bitmap_text_word_wrap_layout
  import btww_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] character
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [15:0] pos_x, [23:16] pos_y, [72:24] glyph_rows
  output logic              m_tuser,   // [0] visible
  output logic              m_tlast,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

`include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LIMIT = 3'd1;
  localparam logic [2:0] ST_NEED  = 3'd2;
  localparam logic [2:0] ST_WRAP  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;
  localparam logic [2:0] ST_SEND  = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]       state;
  logic             font_select;
  logic [7:0]       max_line_length;
  logic [7:0]       start_x;
  logic [7:0]       start_y;

  logic [IDX_W-1:0] word_count;
  logic [IDX_W-1:0] idx;
  logic [15:0]      cursor_x;
  logic [7:0]       cursor_y;
  logic             loaded;
  logic [15:0]      limit;
  logic [15:0]      emit_x;

  logic [7:0]       store [WORD_CAPACITY];
  logic [7:0]       rd_data;
  logic             wr_en;

  logic [2:0]       pitch;
  logic [15:0]      add_a;
  logic [15:0]      add_b;
  logic [15:0]      sum;
  logic             in_hs;
  logic             is_break;
  logic             is_last;
  glyph_t           glyph;

  assign pitch    = font_select ? PITCH_LARGE : PITCH_SMALL;
  assign s_tready = (state == ST_IDLE);
  assign in_hs    = s_tvalid && s_tready;
  assign is_break = (s_tdata == CH_NUL) || (s_tdata == CH_SPACE);
  assign wr_en    = in_hs && !is_break && (word_count < IDX_W'(WORD_CAPACITY));
  assign is_last  = (idx == IDX_W'(word_count - IDX_W'(1)));
  assign glyph    = glyph_lookup(rd_data, font_select);

  // shared adder, operands picked by the sequencer step
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state)
      ST_LIMIT: begin
        add_a = {8'd0, start_x};
        add_b = {5'd0, 11'({3'd0, max_line_length} * {8'd0, pitch})};
      end
      ST_NEED: begin
        add_a = cursor_x;
        add_b = {8'd0, 8'({3'd0, word_count} * {5'd0, pitch})};
      end
      ST_WRAP: begin
        add_a = {8'd0, cursor_y};
        add_b = {13'd0, pitch};
      end
      ST_SEND: begin
        add_a = emit_x;
        add_b = {13'd0, pitch};
      end
      ST_FIN: begin
        add_a = emit_x;
        add_b = {13'd0, GAP_WIDTH};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign sum = add_a + add_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[word_count] <= s_tdata;
    end
    rd_data <= store[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      font_select     <= 1'b0;
      max_line_length <= 8'd63;
      start_x         <= 8'd0;
      start_y         <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FONT:   font_select     <= cfg_data[0];
        REG_MAXLEN: max_line_length <= cfg_data;
        REG_STARTX: start_x         <= cfg_data;
        REG_STARTY: start_y         <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      word_count <= '0;
      idx        <= '0;
      cursor_x   <= '0;
      cursor_y   <= '0;
      loaded     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_hs) begin
            if (!loaded) begin
              cursor_x <= {8'd0, start_x};
              cursor_y <= start_y;
            end
            loaded <= (s_tdata != CH_NUL);
            idx    <= '0;
            emit_x <= loaded ? cursor_x : {8'd0, start_x};
            if (wr_en) begin
              word_count <= word_count + IDX_W'(1);
            end
            if (is_break) begin
              if (word_count != '0)          state <= ST_LIMIT;
              else if (s_tdata == CH_SPACE)  state <= ST_FIN;
            end
          end
        end
        ST_LIMIT: begin
          limit <= sum;
          state <= ST_NEED;
        end
        ST_NEED: begin
          if (sum > limit) begin
            cursor_x <= {8'd0, start_x};
            emit_x   <= {8'd0, start_x};
            state    <= ST_WRAP;
          end else begin
            emit_x <= cursor_x;
            state  <= ST_READ;
          end
        end
        ST_WRAP: begin
          cursor_y <= sum[7:0];
          state    <= ST_READ;
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          m_tdata  <= {{(DATA_W - ROWS_W - 24){1'b0}}, glyph.rows, cursor_y, emit_x};
          m_tuser  <= glyph.vis;
          m_tlast  <= is_last;
          m_tvalid <= 1'b1;
          state    <= ST_SEND;
        end
        ST_SEND: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            emit_x   <= sum;
            idx      <= idx + IDX_W'(1);
            state    <= m_tlast ? ST_FIN : ST_READ;
          end
        end
        ST_FIN: begin
          cursor_x   <= sum;
          word_count <= '0;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_out_only_in_send, clk, rst, m_tvalid |-> (state == ST_SEND), "result valid outside send step")
  `ASSERT_CLK(a_no_input_while_out, clk, rst, m_tvalid |-> !s_tready, "input taken while result pending")
  `ASSERT_CLK(a_idx_in_word, clk, rst, (state == ST_READ || state == ST_LOAD || state == ST_SEND) |-> (idx < word_count), "read index past word")
  `ASSERT_CLK(a_last_ends_word, clk, rst, (m_tvalid && m_tready && m_tlast) |=> (state == ST_FIN), "last transaction did not end word")
  `ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (state == ST_IDLE && !m_tvalid), "sequencer not idle after reset")

endmodule

[tb/sv/bitmap_text_word_wrap_layout_test.sv]
// Self-checking testbench for the word-wrap text layout block: directed table, then random text.
`timescale 1ns / 100ps

module bitmap_text_word_wrap_layout_test;
  import btww_pkg::*;

  localparam int TOTAL_CHARS   = 415;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_PRINTED   = 40;
  localparam int SMALL_PITCH   = 5;
  localparam int LARGE_PITCH   = 6;
  localparam int WORD_GAP      = 3;

  typedef enum logic {ROW_CHAR, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [7:0]  val;
    logic        typed;
    logic [15:0] x;
    logic [7:0]  y;
    logic        vis;
  } step_t;

  typedef struct packed {
    logic [15:0] x;
    logic [7:0]  y;
    logic        vis;
    logic [48:0] rows;
    logic        last;
  } placement_t;

  // Directed text; typed rows are single-character words whose position is obvious.
  localparam step_t DIRECTED [27] = '{
    '{ROW_CHAR, 2'd0, CH_A,      1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_SPACE,  1'b1, 16'd0,   8'd0, 1'b1},
    '{ROW_CHAR, 2'd0, CH_SPACE,  1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_Z,      1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_NUL,    1'b1, 16'd11,  8'd0, 1'b1},
    '{ROW_CHAR, 2'd0, CH_0,      1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_9,      1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_COMMA,  1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_PERIOD, 1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_SLASH,  1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, 8'hFF,     1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, 8'h80,     1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, 8'h7F,     1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, 8'h01,     1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_SPACE,  1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_NUL,    1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_REG,  REG_FONT,   8'd1,   1'b0, 16'd0, 8'd0, 1'b0},
    '{ROW_REG,  REG_MAXLEN, 8'd0,   1'b0, 16'd0, 8'd0, 1'b0},
    '{ROW_REG,  REG_STARTX, 8'hFF,  1'b0, 16'd0, 8'd0, 1'b0},
    '{ROW_REG,  REG_STARTY, 8'hFF,  1'b0, 16'd0, 8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, 8'h4D,     1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_SPACE,  1'b1, 16'd255, 8'd5, 1'b1},
    '{ROW_CHAR, 2'd0, 8'h37,     1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_9,      1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_COMMA,  1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, 8'h36,     1'b0, 16'd0,   8'd0, 1'b0},
    '{ROW_CHAR, 2'd0, CH_NUL,    1'b0, 16'd0,   8'd0, 1'b0}
  };

  // 4x4 glyphs, row 0 in the top nibble
  logic [15:0] font4 [39] = '{
    16'hF9F9, 16'h8EAE, 16'hF88F, 16'hE99E, 16'hFE8F, 16'hFE88, 16'hF89F, 16'h88F9,
    16'h4444, 16'h444C, 16'hACA9, 16'h888F, 16'h9F99, 16'h9DB9, 16'hF99F, 16'hF9E8,
    16'hF9F1, 16'hE9CA, 16'hF81F, 16'hF444, 16'h999F, 16'h9531, 16'h9996, 16'h0A4A,
    16'h9622, 16'hF42F,
    16'h6AAC, 16'h2622, 16'h6246, 16'h6316, 16'h5711, 16'h6426, 16'h4653, 16'h7511,
    16'h7577, 16'h6531,
    16'h0048, 16'h0066, 16'h1248
  };

  // 7x7 glyphs, only letters and digits 0..6
  logic [6:0] font7 [33][7] = '{
    '{7'h00,7'h18,7'h24,7'h24,7'h3C,7'h24,7'h00}, '{7'h00,7'h3C,7'h20,7'h38,7'h24,7'h38,7'h00},
    '{7'h00,7'h38,7'h24,7'h38,7'h24,7'h38,7'h00}, '{7'h00,7'h3C,7'h20,7'h20,7'h20,7'h20,7'h00},
    '{7'h00,7'h0C,7'h14,7'h14,7'h3E,7'h22,7'h00}, '{7'h00,7'h3C,7'h20,7'h38,7'h20,7'h3C,7'h00},
    '{7'h00,7'h2A,7'h2A,7'h1C,7'h2A,7'h2A,7'h00}, '{7'h00,7'h18,7'h04,7'h18,7'h04,7'h18,7'h00},
    '{7'h00,7'h22,7'h26,7'h2A,7'h32,7'h22,7'h00}, '{7'h14,7'h08,7'h22,7'h26,7'h2A,7'h32,7'h00},
    '{7'h00,7'h24,7'h28,7'h30,7'h28,7'h24,7'h00}, '{7'h00,7'h0C,7'h14,7'h14,7'h14,7'h24,7'h00},
    '{7'h00,7'h22,7'h36,7'h2A,7'h22,7'h22,7'h00}, '{7'h00,7'h24,7'h24,7'h3C,7'h24,7'h24,7'h00},
    '{7'h00,7'h18,7'h24,7'h24,7'h24,7'h18,7'h00}, '{7'h00,7'h3C,7'h24,7'h24,7'h24,7'h24,7'h00},
    '{7'h00,7'h38,7'h24,7'h24,7'h38,7'h20,7'h00}, '{7'h00,7'h1C,7'h20,7'h20,7'h20,7'h1C,7'h00},
    '{7'h00,7'h3E,7'h08,7'h08,7'h08,7'h08,7'h00}, '{7'h00,7'h24,7'h24,7'h1C,7'h04,7'h38,7'h00},
    '{7'h00,7'h1C,7'h2A,7'h2A,7'h1C,7'h08,7'h00}, '{7'h00,7'h22,7'h14,7'h08,7'h14,7'h22,7'h00},
    '{7'h00,7'h24,7'h24,7'h24,7'h24,7'h3E,7'h02}, '{7'h00,7'h24,7'h24,7'h1C,7'h04,7'h04,7'h00},
    '{7'h00,7'h2A,7'h2A,7'h2A,7'h2A,7'h3E,7'h00}, '{7'h00,7'h2A,7'h2A,7'h2A,7'h2A,7'h3F,7'h01},
    '{7'h00,7'h30,7'h10,7'h1C,7'h12,7'h1C,7'h00}, '{7'h00,7'h42,7'h42,7'h72,7'h4A,7'h72,7'h00},
    '{7'h00,7'h20,7'h20,7'h38,7'h24,7'h38,7'h00}, '{7'h00,7'h38,7'h04,7'h1C,7'h04,7'h38,7'h00},
    '{7'h00,7'h4C,7'h52,7'h72,7'h52,7'h4C,7'h00}, '{7'h00,7'h1C,7'h24,7'h1C,7'h24,7'h24,7'h00},
    '{7'h14,7'h3C,7'h20,7'h38,7'h20,7'h3C,7'h00}
  };

  logic              clk;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  logic              cfg_we    = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [7:0]        cfg_data  = '0;

  // Layout state mirrored from the block
  logic        lay_font    = 1'b0;
  logic [7:0]  lay_maxlen  = 8'd63;
  logic [7:0]  lay_start_x = 8'd0;
  logic [7:0]  lay_start_y = 8'd0;
  logic [7:0]  word_buf [WORD_CAPACITY];
  int          word_len    = 0;
  logic [15:0] cur_x       = '0;
  logic [15:0] cur_y       = '0;
  bit          pos_loaded  = 1'b0;

  placement_t  placement_q [$];

  int  errors        = 0;
  int  cycles        = 0;
  int  chars_sent    = 0;
  int  placed_checked = 0;
  int  line_wraps    = 0;
  int  settings_used = 1;
  int  burst_left    = 0;
  bit  cfg_open      = 1'b0;

  bitmap_text_word_wrap_layout DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (errors < MAX_PRINTED)
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // {visible, rows} for one byte in the selected font
  function automatic logic [49:0] glyph_of(input logic [7:0] c, input logic big);
    int          idx;
    logic [48:0] rows;
    logic [15:0] s;
    idx  = -1;
    rows = '0;
    if (c >= CH_A && c <= CH_Z)      idx = c - CH_A;
    else if (c >= CH_0 && c <= CH_9) idx = c - CH_0 + 26;
    else if (c == CH_COMMA)          idx = 36;
    else if (c == CH_PERIOD)         idx = 37;
    else if (c == CH_SLASH)          idx = 38;
    if (idx < 0) return '0;
    if (!big) begin
      s = font4[idx];
      for (int r = 0; r < 4; r++) rows[48 - 7*r -: 4] = s[15 - 4*r -: 4];
      return {1'b1, rows};
    end
    // short 7x7 table: 7, 8, 9 and punctuation have no glyph
    if (idx >= 33) return '0;
    for (int r = 0; r < 7; r++) rows[48 - 7*r -: 7] = font7[idx][r];
    return {1'b1, rows};
  endfunction

  // Advance the layout by one accepted byte and queue the glyph placements it flushes.
  task automatic layout_char(input logic [7:0] c);
    int          pitch;
    logic [15:0] need;
    logic [15:0] limit;
    logic [49:0] g;
    placement_t  p;
    pitch = lay_font ? LARGE_PITCH : SMALL_PITCH;
    if (!pos_loaded) begin
      cur_x      = {8'd0, lay_start_x};
      cur_y      = {8'd0, lay_start_y};
      pos_loaded = 1'b1;
    end
    if (c != CH_NUL && c != CH_SPACE) begin
      if (word_len < WORD_CAPACITY) begin
        word_buf[word_len] = c;
        word_len++;
      end
      return;
    end
    if (word_len > 0) begin
      need  = cur_x + word_len * pitch;
      limit = lay_start_x + lay_maxlen * pitch;
      if (need > limit) begin
        cur_x = {8'd0, lay_start_x};
        cur_y = cur_y + pitch;
        line_wraps++;
      end
      for (int i = 0; i < word_len; i++) begin
        g      = glyph_of(word_buf[i], lay_font);
        p.x    = cur_x + i * pitch;
        p.y    = cur_y[7:0];
        p.vis  = g[49];
        p.rows = g[48:0];
        p.last = (i == word_len - 1);
        placement_q.push_back(p);
      end
      cur_x = cur_x + word_len * pitch + WORD_GAP;
    end else if (c == CH_SPACE) begin
      cur_x = cur_x + WORD_GAP;
    end
    word_len = 0;
    if (c == CH_NUL) pos_loaded = 1'b0;
  endtask

  // Sender: bursts of back-to-back bytes separated by random gaps
  task automatic put_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    layout_char(c);
    chars_sent++;
  endtask

  // Wait for every queued placement, then let any trailing byte finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_open  = 1'b1;
    @(posedge clk);
    case (idx)
      REG_FONT:   lay_font    = val[0];
      REG_MAXLEN: lay_maxlen  = val;
      REG_STARTX: lay_start_x = val;
      REG_STARTY: lay_start_y = val;
      default: ;
    endcase
  endtask

  task automatic close_writes();
    if (cfg_open) begin
      cfg_we   <= 1'b0;
      cfg_open = 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] extreme_or_random();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic new_settings(input bit first);
    logic [7:0] maxlen;
    settle();
    if (first) begin
      write_reg(REG_FONT, 8'd0);
      write_reg(REG_MAXLEN, 8'hFF);
      write_reg(REG_STARTX, 8'd0);
      write_reg(REG_STARTY, 8'd0);
    end else begin
      // short lines half the time or more so wraps and y truncation come often
      maxlen = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 12)) : extreme_or_random();
      write_reg(REG_FONT, 8'($urandom_range(0, 1)));
      write_reg(REG_MAXLEN, maxlen);
      write_reg(REG_STARTX, extreme_or_random());
      write_reg(REG_STARTY, extreme_or_random());
    end
    close_writes();
    settings_used++;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b = 8'(CH_A + $urandom_range(0, 25));
      4, 5:       b = 8'(CH_0 + $urandom_range(0, 9));
      6: begin
        case ($urandom_range(0, 2))
          0:       b = CH_COMMA;
          1:       b = CH_PERIOD;
          default: b = CH_SLASH;
        endcase
      end
      7:       b = 8'(8'h61 + $urandom_range(0, 25));
      default: begin
        b = 8'($urandom_range(1, 255));
        if (b == CH_SPACE) b = 8'h21;
      end
    endcase
    return b;
  endfunction

  // Output checker and receiver stall pattern
  always @(posedge clk) begin : out_check
    placement_t  want;
    ready_mode_e mode;
    int          mode_left;
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d placements pending", cycles, placement_q.size());
      $display("Mismatches found");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (placement_q.size() == 0) begin
        report("unexpected transaction, pos_x", 64'(m_tdata[15:0]), 64'd0);
      end else begin
        want = placement_q.pop_front();
        placed_checked++;
        if (m_tdata[15:0] !== want.x)   report("pos_x", 64'(m_tdata[15:0]), 64'(want.x));
        if (m_tdata[23:16] !== want.y)  report("pos_y", 64'(m_tdata[23:16]), 64'(want.y));
        if (m_tdata[72:24] !== want.rows)
          report("glyph_rows", 64'(m_tdata[72:24]), 64'(want.rows));
        if (m_tuser !== want.vis)       report("visible", 64'(m_tuser), 64'(want.vis));
        if (m_tlast !== want.last)      report("last", 64'(m_tlast), 64'(want.last));
      end
    end
    if (mode_left <= 0) begin
      mode      = ready_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 200);
    end else begin
      mode_left--;
    end
    case (mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:      m_tready <= (cycles % 8) < 4;
    endcase
  end

  initial begin : stimulus
    step_t row;
    placement_t p;
    int words_left;
    int len;
    words_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < $size(DIRECTED); k++) begin
      row = DIRECTED[k];
      if (row.kind == ROW_REG) begin
        if (!cfg_open) settle();
        write_reg(row.idx, row.val);
      end else begin
        if (cfg_open) begin
          close_writes();
          settings_used++;
        end
        put_char(row.val);
        if (row.typed) begin
          p = placement_q.pop_back();
          p.x   = row.x;
          p.y   = row.y;
          p.vis = row.vis;
          placement_q.push_back(p);
        end
      end
    end

    new_settings(1'b1);
    while (chars_sent < TOTAL_CHARS) begin
      if (words_left == 0) begin
        if (chars_sent > $size(DIRECTED) + 40) new_settings(1'b0);
        words_left = $urandom_range(6, 14);
      end
      words_left--;
      if ($urandom_range(0, 9) == 0) begin
        // noise: any byte at all, including stray spaces and NULs
        len = $urandom_range(1, 6);
        repeat (len) put_char(8'($urandom_range(0, 255)));
      end else begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(29, 40) : $urandom_range(1, 7);
        repeat (len) put_char(text_byte());
        case ($urandom_range(0, 9))
          0, 1: put_char(CH_NUL);
          2: begin
            put_char(CH_SPACE);
            put_char(CH_SPACE);
          end
          default: put_char(CH_SPACE);
        endcase
      end
    end
    put_char(CH_NUL);
    settle();

    $display("Sent %0d text bytes under %0d register settings", chars_sent, settings_used);
    $display("Checked %0d glyph placements, %0d line wraps", placed_checked, line_wraps);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/btww_pkg.sv
sv/bitmap_text_word_wrap_layout.sv
tb/sv/bitmap_text_word_wrap_layout_test.sv
